/* rtl/stf_pkg.sv */
// package: shared widths, register codes, mode codes and beat structs for the system timer
`timescale 1ns / 1ps

package stf_pkg;

   localparam int CHANNELS_DEF = 4;
   localparam int MAX_CHANNELS = 4;
   localparam int DATA_W       = 32;
   localparam int CNT_W        = 64;
   localparam int IDX_W        = 3;
   localparam int MODE_W       = 2;
   localparam int CSR_IDX_W    = 3;

   // item modes
   localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;

   // bus register map
   localparam logic [IDX_W-1:0] REG_STATUS = 3'd0;
   localparam logic [IDX_W-1:0] REG_CNT_LO = 3'd1;
   localparam logic [IDX_W-1:0] REG_CNT_HI = 3'd2;
   localparam logic [IDX_W-1:0] REG_CMP0   = 3'd3;

   // configuration register map
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RELOAD    = 3'd4;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [IDX_W-1:0]  reg_index;
      logic [DATA_W-1:0] write_data;
   } item_type;

   typedef struct packed {
      logic [DATA_W-1:0]       read_data;
      logic [MAX_CHANNELS-1:0] match_status;
      logic [MAX_CHANNELS-1:0] irq_lines;
   } result_type;

endpackage

/* rtl/stf_if.sv */
// interfaces: request and response channels of the system timer
`timescale 1ns / 1ps

interface stf_req_if;
   logic                      valid;
   logic                      ready;
   logic [stf_pkg::MODE_W-1:0] mode;
   logic [stf_pkg::IDX_W-1:0]  reg_index;
   logic [stf_pkg::DATA_W-1:0] write_data;

   modport source (output valid, mode, reg_index, write_data, input ready);
   modport sink   (input valid, mode, reg_index, write_data, output ready);
endinterface

interface stf_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [stf_pkg::DATA_W-1:0]       read_data;
   logic [stf_pkg::MAX_CHANNELS-1:0] match_status;
   logic [stf_pkg::MAX_CHANNELS-1:0] irq_lines;

   modport source (output valid, read_data, match_status, irq_lines, input ready);
   modport sink   (input valid, read_data, match_status, irq_lines, output ready);
endinterface

/* rtl/stf_exec.sv */
// execution stage: counter, compare channels, status and configuration registers
`timescale 1ns / 1ps

module stf_exec #(
   parameter int CHANNELS = stf_pkg::CHANNELS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [stf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [stf_pkg::DATA_W-1:0]    csr_wdata,
   input  logic                          fire,
   input  stf_pkg::item_type             item,
   output stf_pkg::result_type           result
);

   localparam logic [stf_pkg::MAX_CHANNELS-1:0] ChanMask =
      stf_pkg::MAX_CHANNELS'((1 << CHANNELS) - 1);

   logic [stf_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic [stf_pkg::DATA_W-1:0]       cmp_ff [CHANNELS];
   logic [stf_pkg::DATA_W-1:0]       cmp_in [CHANNELS];
   logic [stf_pkg::DATA_W-1:0]       interval_ff [CHANNELS];
   logic [stf_pkg::DATA_W-1:0]       interval_in [CHANNELS];
   logic [stf_pkg::MAX_CHANNELS-1:0] status_ff, status_in;
   logic [stf_pkg::MAX_CHANNELS-1:0] reload_ff, reload_in;
   logic [stf_pkg::CNT_W-1:0]        cnt_next;
   logic [stf_pkg::DATA_W-1:0]       low_next;
   logic [stf_pkg::DATA_W-1:0]       rd;

   assign cnt_next = cnt_ff + stf_pkg::CNT_W'(1);
   assign low_next = cnt_next[stf_pkg::DATA_W-1:0];

   always_comb begin
      cnt_in    = cnt_ff;
      status_in = status_ff;
      rd        = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         cmp_in[c] = cmp_ff[c];
      end
      case (item.mode)
         stf_pkg::MODE_TICK: begin
            cnt_in = cnt_next;
            for (int c = 0; c < CHANNELS; c++) begin
               if (cmp_ff[c] == low_next) begin
                  status_in[c] = 1'b1;
                  // rearm wraps at 32 bits
                  if (reload_ff[c]) begin
                     cmp_in[c] = low_next + interval_ff[c];
                  end
               end
            end
         end
         stf_pkg::MODE_READ: begin
            case (item.reg_index)
               stf_pkg::REG_STATUS: begin
                  rd = stf_pkg::DATA_W'(status_ff);
               end
               stf_pkg::REG_CNT_LO: begin
                  rd = cnt_ff[stf_pkg::DATA_W-1:0];
               end
               stf_pkg::REG_CNT_HI: begin
                  rd = cnt_ff[stf_pkg::CNT_W-1:stf_pkg::DATA_W];
               end
               default: begin
                  for (int c = 0; c < CHANNELS; c++) begin
                     if (item.reg_index == stf_pkg::IDX_W'(stf_pkg::REG_CMP0 + c)) begin
                        rd = cmp_ff[c];
                     end
                  end
               end
            endcase
         end
         stf_pkg::MODE_WRITE: begin
            if (item.reg_index == stf_pkg::REG_STATUS) begin
               status_in = status_ff & ~item.write_data[stf_pkg::MAX_CHANNELS-1:0];
            end
            for (int c = 0; c < CHANNELS; c++) begin
               if (item.reg_index == stf_pkg::IDX_W'(stf_pkg::REG_CMP0 + c)) begin
                  cmp_in[c] = item.write_data;
               end
            end
         end
         default: begin
            // idle item, nothing changes
            cnt_in = cnt_ff;
         end
      endcase
      status_in = status_in & ChanMask;
   end

   always_comb begin
      reload_in = reload_ff;
      for (int c = 0; c < CHANNELS; c++) begin
         interval_in[c] = interval_ff[c];
         if (csr_we && csr_index == stf_pkg::CSR_IDX_W'(stf_pkg::CSR_INTERVAL0 + c)) begin
            interval_in[c] = csr_wdata;
         end
      end
      if (csr_we && csr_index == stf_pkg::CSR_RELOAD) begin
         reload_in = csr_wdata[stf_pkg::MAX_CHANNELS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         status_ff <= '0;
         reload_ff <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            cmp_ff[c]      <= '0;
            interval_ff[c] <= '0;
         end
      end else begin
         reload_ff <= reload_in;
         for (int c = 0; c < CHANNELS; c++) begin
            interval_ff[c] <= interval_in[c];
         end
         if (fire) begin
            cnt_ff    <= cnt_in;
            status_ff <= status_in;
            for (int c = 0; c < CHANNELS; c++) begin
               cmp_ff[c] <= cmp_in[c];
            end
         end
      end
   end

   assign result.read_data    = rd;
   assign result.match_status = status_in;
   assign result.irq_lines    = status_in;

endmodule

/* rtl/system_timer_four_compare.sv */
// top level: input register, execution stage and result register of the system timer
//
//   channel  dir  handshake      payload
//   req_chan in   valid/ready    mode, reg_index, write_data
//   rsp_chan out  valid/ready    read_data, match_status, irq_lines
//   csr_*    in   write enable   csr_index, csr_wdata
//
// one beat per cycle sustained while rsp_chan is ready; each beat waits in the input
// register, then passes to the result register that drives rsp_chan
// the 64-bit counter increment and four 32-bit compares sit between the two registers
// synchronous reset clears counter, compares, status, intervals and both valid flags
// a stalled result holds in the result register while the input register still fills
`timescale 1ns / 1ps

module system_timer_four_compare #(
   parameter int CHANNELS = stf_pkg::CHANNELS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   stf_req_if.sink                       req_chan,
   stf_rsp_if.source                     rsp_chan,
   input  logic                          csr_we,
   input  logic [stf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [stf_pkg::DATA_W-1:0]    csr_wdata
);

   logic                in_valid_ff;
   stf_pkg::item_type   in_ff;
   logic                out_valid_ff;
   stf_pkg::result_type out_ff;
   stf_pkg::result_type result;
   logic                out_load;
   logic                fire;
   logic                req_beat;

   assign out_load       = !out_valid_ff || rsp_chan.ready;
   assign fire           = in_valid_ff && out_load;
   assign req_chan.ready = !in_valid_ff || out_load;
   assign req_beat       = req_chan.valid && req_chan.ready;

   stf_exec #(
      .CHANNELS(CHANNELS)
   ) u_exec (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fire      (fire),
      .item      (in_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (out_load) begin
            out_valid_ff <= in_valid_ff;
         end
      end
      if (req_beat) begin
         in_ff.mode       <= req_chan.mode;
         in_ff.reg_index  <= req_chan.reg_index;
         in_ff.write_data <= req_chan.write_data;
      end
      if (fire) begin
         out_ff <= result;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.read_data    = out_ff.read_data;
   assign rsp_chan.match_status = out_ff.match_status;
   assign rsp_chan.irq_lines    = out_ff.irq_lines;

endmodule

/* rtl/stf_checker.sv */
// checker: port-level assertions for the system timer, bound to the top level
`timescale 1ns / 1ps

module stf_checker #(
   parameter int CHANNELS = stf_pkg::CHANNELS_DEF
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [stf_pkg::DATA_W-1:0]       rsp_read_data,
   input logic [stf_pkg::MAX_CHANNELS-1:0] rsp_match_status,
   input logic [stf_pkg::MAX_CHANNELS-1:0] rsp_irq_lines
);

   localparam logic [stf_pkg::MAX_CHANNELS-1:0] ChanMask =
      stf_pkg::MAX_CHANNELS'((1 << CHANNELS) - 1);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
         && $stable(rsp_match_status))
      else $error("stalled result beat changed");

   a_irq_eq_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_irq_lines == rsp_match_status)
      else $error("irq lines differ from match status");

   a_absent_chan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_match_status & ~ChanMask) == '0)
      else $error("status set on an absent channel");

   // a fresh result beat follows a request beat taken into the input register
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result beat without a request beat");

endmodule

bind system_timer_four_compare stf_checker #(
   .CHANNELS(CHANNELS)
) u_stf_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_read_data    (rsp_chan.read_data),
   .rsp_match_status (rsp_chan.match_status),
   .rsp_irq_lines    (rsp_chan.irq_lines)
);
